[hdl/c80_pkg.sv]
// Shared types, constants and decode helpers for the 8080-style core.
package c80_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
    localparam int IN_W          = 32;
    localparam int OUT_W         = 120;

    localparam logic [15:0] SP_RESET = 16'd32;
    localparam logic [7:0]  OP_HLT   = 8'h76;
    localparam logic [7:0]  OP_RET   = 8'hc9;
    localparam logic [7:0]  OP_XTHL  = 8'he3;
    localparam logic [7:0]  OP_LDAXB = 8'h0a;
    localparam logic [7:0]  OP_LDAXD = 8'h1a;
    localparam logic [7:0]  OP_LHLD  = 8'h2a;
    localparam logic [7:0]  OP_LDA   = 8'h3a;
    localparam logic [7:0]  OP_INRM  = 8'h34;
    localparam logic [7:0]  OP_DCRM  = 8'h35;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_EXEC  = 2'd2,
        KIND_INBUF = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FOP, ST_IMM1, ST_IMM2,
        ST_RDISS, ST_RD1, ST_RD2, ST_EXEC, ST_WR2, ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        SRC_HL, SRC_BC, SRC_DE, SRC_IMM, SRC_SP
    } rd_src_t;

    typedef struct packed {
        logic [1:0] nimm;
        logic [1:0] nrd;
        rd_src_t    src;
    } plan_t;

    typedef struct packed {
        logic [7:0]  b, c, d, e, h, l, a;
        logic        fs, fz, fac, fp, fcy;
        logic [15:0] pc, sp;
        logic        halted, ie;
        logic [7:0]  in_buf, out_buf;
    } cpu_state_t;

    typedef struct packed {
        logic        en1, en2;
        logic [15:0] addr1, addr2;
        logic [7:0]  data1, data2;
    } wr_plan_t;

    // architectural state after reset: all zero but SP
    function automatic cpu_state_t reset_state();
        cpu_state_t s;
        s = '0;
        s.sp = SP_RESET;
        reset_state = s;
    endfunction

    function automatic logic [7:0] flags_byte(input cpu_state_t s);
        flags_byte = {s.fs, s.fz, 1'b0, s.fac, 1'b0, s.fp, 1'b1, s.fcy};
    endfunction

    // immediate byte count and operand reads of an opcode
    function automatic plan_t decode(input logic [7:0] op);
        plan_t pl;
        pl.nimm = 2'd0;
        pl.nrd  = 2'd0;
        pl.src  = SRC_HL;
        if (op[7:6] == 2'b00) begin
            if (op[2:0] == 3'd1 && !op[3]) pl.nimm = 2'd2;
            if (op[2:0] == 3'd2 && op[5]) pl.nimm = 2'd2;
            if (op[2:0] == 3'd6) pl.nimm = 2'd1;
            if (op == OP_INRM || op == OP_DCRM) pl.nrd = 2'd1;
            if (op == OP_LDAXB) begin pl.nrd = 2'd1; pl.src = SRC_BC; end
            if (op == OP_LDAXD) begin pl.nrd = 2'd1; pl.src = SRC_DE; end
            if (op == OP_LHLD) begin pl.nrd = 2'd2; pl.src = SRC_IMM; end
            if (op == OP_LDA) begin pl.nrd = 2'd1; pl.src = SRC_IMM; end
        end else if (op[7:6] == 2'b11) begin
            case (op[2:0])
                3'd2, 3'd4: pl.nimm = 2'd2;
                3'd3: begin
                    if (op[5:3] == 3'd0) pl.nimm = 2'd2;
                    else if (op[5:3] <= 3'd3) pl.nimm = 2'd1;
                end
                3'd5: if (op[3]) pl.nimm = 2'd2;
                3'd6: pl.nimm = 2'd1;
                default: ;
            endcase
            if (op[2:0] == 3'd0 || (op[2:0] == 3'd1 && !op[3]) || op == OP_RET
                || op == OP_XTHL) begin
                pl.nrd = 2'd2;
                pl.src = SRC_SP;
            end
        end else if (op != OP_HLT && op[2:0] == 3'd6) begin
            pl.nrd = 2'd1;
        end
        decode = pl;
    endfunction

endpackage

[hdl/cpu_8080_instruction_core.sv]
// Top level of the 8080-style core: item sequencer, architectural registers and memory.
//
// Usage: items arrive on the s_ stream (opcode, address, data); each one gives exactly
// one result transfer on the m_ stream carrying the full register and flag snapshot.
// Opcode 0 writes a memory byte, 1 reads one, 3 loads the input-port buffer and
// 2 executes the instruction at PC. The user writes the single config bit console_mode
// through cfg_wr_en/cfg_wr_data only while idle; the core itself never checks this.
// Sequence: a memory or buffer item goes from IDLE to FIN, where the result register
// loads once the output is free. An executed instruction issues its opcode fetch in
// IDLE, then passes FOP, IMM1/IMM2 for each immediate byte, RDISS to issue the operand
// reads with RD1/RD2 for each operand byte read, EXEC, WR2 for a second stored byte,
// and FIN. All of that is set by the single port of the byte memory, one access per
// cycle, with registered read data. One item is in flight at a time.
// Reset: aresetn low clears the architectural and control registers (SP to 32), then
// a clearing pass zeroes all 65536 memory bytes, one per cycle, before s_tready rises.
// Stall: the result sits in an output register; the next item can be accepted
// while it waits, and the core holds before loading a new result until m_tready.
module cpu_8080_instruction_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // opcode[1:0], address[17:2], data[25:18], zero fill
    input  logic [c80_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // read_data[7:0], pc[23:8], sp[39:24], reg_a[47:40], flag_byte[55:48],
    // pair_bc[71:56], pair_de[87:72], pair_hl[103:88], halted[104],
    // irq_enabled[105], out_valid[106], out_byte[114:107], zero fill
    output logic [c80_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data
);
    localparam int AW = c80_pkg::MEM_ADDR_BITS;

    c80_pkg::state_t     state_reg, state_next;
    c80_pkg::cpu_state_t cpu_reg, st_next;
    c80_pkg::wr_plan_t   wr;
    c80_pkg::plan_t      plan_f, plan_ir;
    c80_pkg::kind_t      kind;

    logic [7:0]  ir_reg, lo_reg, hi_reg, d1_reg, d2_reg;
    logic [15:0] w2_addr_reg;
    logic [7:0]  w2_data_reg;
    logic        emit_v_reg, is_read_reg, m_tvalid_reg, console_mode_reg;
    logic [7:0]  emit_b_reg;
    logic [c80_pkg::OUT_W-1:0] m_tdata_reg;
    logic [AW-1:0] clr_addr_reg;

    logic        accept, emit_valid, out_free;
    logic [7:0]  emit_byte, ram_rdata, out_byte;
    logic        ram_en, ram_we;
    logic [15:0] ram_addr16, rd_addr;
    logic [7:0]  ram_wdata;

    assign kind     = c80_pkg::kind_t'(s_tdata[1:0]);
    assign s_tready = (state_reg == c80_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign plan_f   = c80_pkg::decode(ram_rdata);
    assign plan_ir  = c80_pkg::decode(ir_reg);

    always_comb begin
        case (plan_ir.src)
            c80_pkg::SRC_BC:  rd_addr = {cpu_reg.b, cpu_reg.c};
            c80_pkg::SRC_DE:  rd_addr = {cpu_reg.d, cpu_reg.e};
            c80_pkg::SRC_IMM: rd_addr = {hi_reg, lo_reg};
            c80_pkg::SRC_SP:  rd_addr = cpu_reg.sp;
            default:          rd_addr = {cpu_reg.h, cpu_reg.l};
        endcase
    end

    c80_exec u_exec (
        .st           (cpu_reg),
        .ir           (ir_reg),
        .imm          ({hi_reg, lo_reg}),
        .d1           (d1_reg),
        .d2           (d2_reg),
        .console_mode (console_mode_reg),
        .st_next      (st_next),
        .wr           (wr),
        .emit_valid   (emit_valid),
        .emit_byte    (emit_byte)
    );

    c80_ram #(.WIDTH(8), .DEPTH(c80_pkg::MEM_DEPTH)) u_mem (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr16[AW-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            c80_pkg::ST_CLEAR:
                if (clr_addr_reg == {AW{1'b1}}) state_next = c80_pkg::ST_IDLE;
            c80_pkg::ST_IDLE:
                if (accept) begin
                    if (kind == c80_pkg::KIND_EXEC && !cpu_reg.halted)
                        state_next = c80_pkg::ST_FOP;
                    else state_next = c80_pkg::ST_FIN;
                end
            c80_pkg::ST_FOP: begin
                if (plan_f.nimm != 2'd0) state_next = c80_pkg::ST_IMM1;
                else if (plan_f.nrd != 2'd0) state_next = c80_pkg::ST_RDISS;
                else state_next = c80_pkg::ST_EXEC;
            end
            c80_pkg::ST_IMM1: begin
                if (plan_ir.nimm == 2'd2) state_next = c80_pkg::ST_IMM2;
                else if (plan_ir.nrd != 2'd0) state_next = c80_pkg::ST_RDISS;
                else state_next = c80_pkg::ST_EXEC;
            end
            c80_pkg::ST_IMM2:
                state_next = (plan_ir.nrd != 2'd0) ? c80_pkg::ST_RDISS : c80_pkg::ST_EXEC;
            c80_pkg::ST_RDISS: state_next = c80_pkg::ST_RD1;
            c80_pkg::ST_RD1:
                state_next = (plan_ir.nrd == 2'd2) ? c80_pkg::ST_RD2 : c80_pkg::ST_EXEC;
            c80_pkg::ST_RD2: state_next = c80_pkg::ST_EXEC;
            c80_pkg::ST_EXEC: state_next = wr.en2 ? c80_pkg::ST_WR2 : c80_pkg::ST_FIN;
            c80_pkg::ST_WR2: state_next = c80_pkg::ST_FIN;
            c80_pkg::ST_FIN: if (out_free) state_next = c80_pkg::ST_IDLE;
            default: state_next = c80_pkg::ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr16 = cpu_reg.pc;
        ram_wdata  = 8'd0;
        case (state_reg)
            c80_pkg::ST_CLEAR: begin
                ram_en = 1'b1; ram_we = 1'b1;
                ram_addr16 = 16'(clr_addr_reg);
            end
            c80_pkg::ST_IDLE:
                if (accept) begin
                    case (kind)
                        c80_pkg::KIND_WRITE: begin
                            ram_en = 1'b1; ram_we = 1'b1;
                            ram_addr16 = s_tdata[17:2]; ram_wdata = s_tdata[25:18];
                        end
                        c80_pkg::KIND_READ: begin
                            ram_en = 1'b1; ram_addr16 = s_tdata[17:2];
                        end
                        c80_pkg::KIND_EXEC: ram_en = !cpu_reg.halted;
                        default: ;
                    endcase
                end
            c80_pkg::ST_FOP: begin
                ram_en = (plan_f.nimm != 2'd0);
                ram_addr16 = cpu_reg.pc + 16'd1;
            end
            c80_pkg::ST_IMM1: begin
                ram_en = (plan_ir.nimm == 2'd2);
                ram_addr16 = cpu_reg.pc + 16'd1;
            end
            c80_pkg::ST_RDISS: begin
                ram_en = 1'b1; ram_addr16 = rd_addr;
            end
            c80_pkg::ST_RD1: begin
                ram_en = (plan_ir.nrd == 2'd2); ram_addr16 = rd_addr + 16'd1;
            end
            c80_pkg::ST_EXEC: begin
                ram_en = wr.en1; ram_we = 1'b1;
                ram_addr16 = wr.addr1; ram_wdata = wr.data1;
            end
            c80_pkg::ST_WR2: begin
                ram_en = 1'b1; ram_we = 1'b1;
                ram_addr16 = w2_addr_reg; ram_wdata = w2_data_reg;
            end
            default: ;
        endcase
    end

    assign out_byte = emit_v_reg ? emit_b_reg : cpu_reg.out_buf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= c80_pkg::ST_CLEAR;
            clr_addr_reg     <= '0;
            cpu_reg          <= c80_pkg::reset_state();
            m_tvalid_reg     <= 1'b0;
            emit_v_reg       <= 1'b0;
            is_read_reg      <= 1'b0;
            console_mode_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) console_mode_reg <= cfg_wr_data;
            if (state_reg == c80_pkg::ST_CLEAR) clr_addr_reg <= clr_addr_reg + AW'(1);
            if (state_reg == c80_pkg::ST_FIN && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            case (state_reg)
                c80_pkg::ST_IDLE:
                    if (accept) begin
                        emit_v_reg  <= 1'b0;
                        is_read_reg <= (kind == c80_pkg::KIND_READ);
                        if (kind == c80_pkg::KIND_INBUF) cpu_reg.in_buf <= s_tdata[25:18];
                    end
                c80_pkg::ST_FOP: begin
                    ir_reg <= ram_rdata;
                    cpu_reg.pc <= cpu_reg.pc + 16'd1;
                end
                c80_pkg::ST_IMM1: begin
                    lo_reg <= ram_rdata;
                    cpu_reg.pc <= cpu_reg.pc + 16'd1;
                end
                c80_pkg::ST_IMM2: begin
                    hi_reg <= ram_rdata;
                    cpu_reg.pc <= cpu_reg.pc + 16'd1;
                end
                c80_pkg::ST_RD1: d1_reg <= ram_rdata;
                c80_pkg::ST_RD2: d2_reg <= ram_rdata;
                c80_pkg::ST_EXEC: begin
                    cpu_reg     <= st_next;
                    w2_addr_reg <= wr.addr2;
                    w2_data_reg <= wr.data2;
                    emit_v_reg  <= emit_valid;
                    emit_b_reg  <= emit_byte;
                end
                c80_pkg::ST_FIN:
                    if (out_free) begin
                        m_tdata_reg <= {5'd0, out_byte, emit_v_reg, cpu_reg.ie, cpu_reg.halted,
                                        cpu_reg.h, cpu_reg.l, cpu_reg.d, cpu_reg.e,
                                        cpu_reg.b, cpu_reg.c, c80_pkg::flags_byte(cpu_reg),
                                        cpu_reg.a, cpu_reg.sp, cpu_reg.pc,
                                        is_read_reg ? ram_rdata : 8'd0};
                    end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

[hdl/c80_ram.sv]
// Generic single-port RAM with registered read.
module c80_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) mem[addr] <= wdata;
            else rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[hdl/c80_exec.sv]
// Instruction execute datapath: register, flag and write-back computation.
module c80_exec (
    input  c80_pkg::cpu_state_t st,
    input  logic [7:0]          ir,
    input  logic [15:0]         imm,
    input  logic [7:0]          d1,
    input  logic [7:0]          d2,
    input  logic                console_mode,
    output c80_pkg::cpu_state_t st_next,
    output c80_pkg::wr_plan_t   wr,
    output logic                emit_valid,
    output logic [7:0]          emit_byte
);
    function automatic c80_pkg::cpu_state_t szp(input c80_pkg::cpu_state_t s,
                                                 input logic [7:0] v);
        c80_pkg::cpu_state_t t;
        t = s;
        t.fs = v[7];
        t.fz = (v == 8'd0);
        t.fp = ~^v;
        szp = t;
    endfunction

    function automatic logic [7:0] get_r(input c80_pkg::cpu_state_t s, input logic [2:0] c,
                                         input logic [7:0] m);
        case (c)
            3'd0: get_r = s.b;
            3'd1: get_r = s.c;
            3'd2: get_r = s.d;
            3'd3: get_r = s.e;
            3'd4: get_r = s.h;
            3'd5: get_r = s.l;
            3'd6: get_r = m;
            default: get_r = s.a;
        endcase
    endfunction

    function automatic c80_pkg::cpu_state_t set_r(input c80_pkg::cpu_state_t s,
                                                   input logic [2:0] c, input logic [7:0] v);
        c80_pkg::cpu_state_t t;
        t = s;
        case (c)
            3'd0: t.b = v;
            3'd1: t.c = v;
            3'd2: t.d = v;
            3'd3: t.e = v;
            3'd4: t.h = v;
            3'd5: t.l = v;
            3'd7: t.a = v;
            default: ;
        endcase
        set_r = t;
    endfunction

    function automatic logic [15:0] get_rp(input c80_pkg::cpu_state_t s, input logic [1:0] p);
        case (p)
            2'd0: get_rp = {s.b, s.c};
            2'd1: get_rp = {s.d, s.e};
            2'd2: get_rp = {s.h, s.l};
            default: get_rp = s.sp;
        endcase
    endfunction

    function automatic c80_pkg::cpu_state_t set_rp(input c80_pkg::cpu_state_t s,
                                                    input logic [1:0] p, input logic [15:0] v);
        c80_pkg::cpu_state_t t;
        t = s;
        case (p)
            2'd0: {t.b, t.c} = v;
            2'd1: {t.d, t.e} = v;
            2'd2: {t.h, t.l} = v;
            default: t.sp = v;
        endcase
        set_rp = t;
    endfunction

    function automatic logic cond(input c80_pkg::cpu_state_t s, input logic [2:0] y);
        case (y)
            3'd0: cond = !s.fz;
            3'd1: cond = s.fz;
            3'd2: cond = !s.fcy;
            3'd3: cond = s.fcy;
            3'd4: cond = !s.fp;
            3'd5: cond = s.fp;
            3'd6: cond = !s.fs;
            default: cond = s.fs;
        endcase
    endfunction

    function automatic c80_pkg::cpu_state_t alu_f(input c80_pkg::cpu_state_t s,
                                                   input logic [2:0] op, input logic [7:0] bv);
        c80_pkg::cpu_state_t t;
        logic       cin;
        logic [8:0] r9;
        logic [4:0] n5;
        logic [7:0] nb;
        t   = s;
        cin = s.fcy && op[0];
        nb  = 8'(~bv + 8'd1);
        r9  = 9'd0;
        n5  = 5'd0;
        case (op)
            3'd0, 3'd1: begin
                r9 = {1'b0, s.a} + {1'b0, bv} + 9'(cin);
                n5 = {1'b0, s.a[3:0]} + {1'b0, bv[3:0]} + 5'(cin);
                t.fac = n5[4];
                t.fcy = r9[8];
                t.a = r9[7:0];
            end
            3'd2, 3'd3: begin
                r9 = {1'b0, s.a} - {1'b0, bv} - 9'(cin);
                n5 = {1'b0, s.a[3:0]} - {1'b0, bv[3:0]} - 5'(cin);
                t.fac = n5[4];
                t.fcy = r9[8];
                t.a = r9[7:0];
            end
            3'd4: begin t.a = s.a & bv; t.fcy = 1'b0; end
            3'd5: begin t.a = s.a ^ bv; t.fcy = 1'b0; end
            3'd6: begin t.a = s.a | bv; t.fcy = 1'b0; end
            default: begin
                // compare: A is kept, flags from A - operand
                r9 = {1'b0, s.a} - {1'b0, bv};
                n5 = {1'b0, s.a[3:0]} + {1'b0, nb[3:0]};
                t.fac = n5[4];
                t.fcy = r9[8];
            end
        endcase
        if (op == 3'd7) t = szp(t, r9[7:0]);
        else t = szp(t, t.a);
        alu_f = t;
    endfunction

    function automatic c80_pkg::cpu_state_t rot_f(input c80_pkg::cpu_state_t s,
                                                   input logic [2:0] k);
        c80_pkg::cpu_state_t t;
        logic [7:0] corr;
        logic [4:0] n5;
        t = s;
        corr = 8'd0;
        case (k)
            3'd0: begin t.a = {s.a[6:0], s.a[7]}; t.fcy = s.a[7]; end
            3'd1: begin t.a = {s.a[0], s.a[7:1]}; t.fcy = s.a[0]; end
            3'd2: begin t.a = {s.a[6:0], s.fcy}; t.fcy = s.a[7]; end
            3'd3: begin t.a = {s.fcy, s.a[7:1]}; t.fcy = s.a[0]; end
            3'd4: begin
                if (s.a[3:0] > 4'd9 || s.fac) corr[3:0] = 4'h6;
                if (s.a > 8'h99 || s.fcy) begin
                    corr[7:4] = 4'h6;
                    t.fcy = 1'b1;
                end
                n5 = {1'b0, s.a[3:0]} + {1'b0, corr[3:0]};
                t.fac = n5[4];
                t.a = s.a + corr;
                t = szp(t, t.a);
            end
            3'd5: t.a = ~s.a;
            3'd6: t.fcy = 1'b1;
            default: t.fcy = !s.fcy;
        endcase
        rot_f = t;
    endfunction

    logic [2:0]  y, z;
    logic [1:0]  p;
    logic [15:0] hl, dm, sum16;
    logic [16:0] dad;
    logic [7:0]  v;

    assign y  = ir[5:3];
    assign z  = ir[2:0];
    assign p  = ir[5:4];
    assign hl = {st.h, st.l};
    assign dm = {d2, d1};

    always_comb begin
        st_next    = st;
        wr         = '0;
        emit_valid = 1'b0;
        emit_byte  = 8'd0;
        v          = 8'd0;
        dad        = 17'd0;
        sum16      = 16'd0;
        if (ir == c80_pkg::OP_HLT) begin
            st_next.halted = 1'b1;
        end else if (ir[7:6] == 2'b01) begin
            v = get_r(st, z, d1);
            if (y == 3'd6) begin
                wr.en1 = 1'b1; wr.addr1 = hl; wr.data1 = v;
            end else st_next = set_r(st, y, v);
        end else if (ir[7:6] == 2'b10) begin
            st_next = alu_f(st, y, get_r(st, z, d1));
        end else if (ir[7:6] == 2'b00) begin
            case (z)
                3'd1: begin
                    if (ir[3]) begin
                        dad = {1'b0, hl} + {1'b0, get_rp(st, p)};
                        st_next.fcy = dad[16];
                        {st_next.h, st_next.l} = dad[15:0];
                    end else st_next = set_rp(st, p, imm);
                end
                3'd2: begin
                    case (y)
                        3'd0: begin wr.en1 = 1'b1; wr.addr1 = {st.b, st.c}; wr.data1 = st.a; end
                        3'd2: begin wr.en1 = 1'b1; wr.addr1 = {st.d, st.e}; wr.data1 = st.a; end
                        3'd4: begin
                            wr.en1 = 1'b1; wr.addr1 = imm; wr.data1 = st.l;
                            wr.en2 = 1'b1; wr.addr2 = imm + 16'd1; wr.data2 = st.h;
                        end
                        3'd5: begin st_next.l = d1; st_next.h = d2; end
                        3'd6: begin wr.en1 = 1'b1; wr.addr1 = imm; wr.data1 = st.a; end
                        default: st_next.a = d1;
                    endcase
                end
                3'd3: begin
                    sum16 = get_rp(st, p) + (ir[3] ? 16'hffff : 16'd1);
                    st_next = set_rp(st, p, sum16);
                end
                3'd4, 3'd5: begin
                    v = get_r(st, y, d1);
                    st_next.fac = z[0] ? (v[3:0] == 4'h0) : (v[3:0] == 4'hf);
                    v = z[0] ? v - 8'd1 : v + 8'd1;
                    st_next = szp(st_next, v);
                    if (y == 3'd6) begin
                        wr.en1 = 1'b1; wr.addr1 = hl; wr.data1 = v;
                    end else st_next = set_r(st_next, y, v);
                end
                3'd6: begin
                    if (y == 3'd6) begin
                        wr.en1 = 1'b1; wr.addr1 = hl; wr.data1 = imm[7:0];
                    end else st_next = set_r(st, y, imm[7:0]);
                end
                3'd7: st_next = rot_f(st, y);
                default: ;
            endcase
        end else begin
            case (z)
                3'd0: begin
                    if (cond(st, y)) begin
                        st_next.pc = dm;
                        st_next.sp = st.sp + 16'd2;
                    end
                end
                3'd1: begin
                    if (ir[3]) begin
                        if (p == 2'd0) begin
                            st_next.pc = dm;
                            st_next.sp = st.sp + 16'd2;
                        end else if (p == 2'd2) st_next.pc = hl;
                        else if (p == 2'd3) st_next.sp = hl;
                    end else if (p == 2'd3) begin
                        st_next.fs = d1[7]; st_next.fz = d1[6]; st_next.fac = d1[4];
                        st_next.fp = d1[2]; st_next.fcy = d1[0];
                        st_next.a = d2;
                        st_next.sp = st.sp + 16'd2;
                    end else begin
                        st_next = set_rp(st, p, dm);
                        st_next.sp = st.sp + 16'd2;
                    end
                end
                3'd2: if (cond(st, y)) st_next.pc = imm;
                3'd3: begin
                    case (y)
                        3'd0: st_next.pc = imm;
                        3'd1, 3'd3: begin
                            if (imm[7:0] == 8'd0) st_next.a = st.in_buf;
                            else if (imm[7:0] == 8'd1) st_next.a = st.out_buf;
                        end
                        3'd2: begin
                            if (imm[7:0] == 8'd0) st_next.in_buf = st.a;
                            else if (imm[7:0] == 8'd1) begin
                                if (console_mode) begin
                                    emit_valid = 1'b1;
                                    emit_byte = st.a;
                                end else st_next.out_buf = st.a;
                            end
                        end
                        3'd4: begin
                            st_next.h = d2; st_next.l = d1;
                            wr.en1 = 1'b1; wr.addr1 = st.sp; wr.data1 = st.l;
                            wr.en2 = 1'b1; wr.addr2 = st.sp + 16'd1; wr.data2 = st.h;
                        end
                        3'd5: begin
                            st_next.h = st.d; st_next.l = st.e;
                            st_next.d = st.h; st_next.e = st.l;
                        end
                        3'd6: st_next.ie = 1'b0;
                        default: st_next.ie = 1'b1;
                    endcase
                end
                3'd4, 3'd5, 3'd7: begin
                    // push group: calls, restarts and PUSH
                    if ((z == 3'd4 && cond(st, y)) || (z == 3'd5 && ir[3]) || z == 3'd7) begin
                        wr.en1 = 1'b1; wr.addr1 = st.sp - 16'd1; wr.data1 = st.pc[15:8];
                        wr.en2 = 1'b1; wr.addr2 = st.sp - 16'd2; wr.data2 = st.pc[7:0];
                        st_next.sp = st.sp - 16'd2;
                        st_next.pc = (z == 3'd7) ? {10'd0, y, 3'd0} : imm;
                    end else if (z == 3'd5) begin
                        sum16 = (p == 2'd3) ? {st.a, c80_pkg::flags_byte(st)} : get_rp(st, p);
                        wr.en1 = 1'b1; wr.addr1 = st.sp - 16'd1; wr.data1 = sum16[15:8];
                        wr.en2 = 1'b1; wr.addr2 = st.sp - 16'd2; wr.data2 = sum16[7:0];
                        st_next.sp = st.sp - 16'd2;
                    end
                end
                default: st_next = alu_f(st, y, imm[7:0]);
            endcase
        end
    end
endmodule

[hdl/c80_checker.sv]
// Port-level assertions for the 8080-style core, bound to the top level.
module c80_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [c80_pkg::OUT_W-1:0] m_tdata
);
    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item in flight
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_flag_const: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[49] == 1'b1 && m_tdata[51] == 1'b0 && m_tdata[53] == 1'b0))
        else $error("fixed flag bits wrong");

    // a console byte is always the accumulator
    a_console: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[106] |-> m_tdata[114:107] == m_tdata[47:40])
        else $error("console byte differs from A");
endmodule

bind cpu_8080_instruction_core c80_checker u_c80_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/cpu_8080_checker.sv]
`timescale 1ns / 1ps
// Checker for the 8080-style core: snoops both streams, predicts each snapshot, compares.
module cpu_8080_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [c80_pkg::IN_W-1:0]   s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [c80_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    output int                         errors,
    output int                         pending,
    output logic [15:0]                next_pc
);
    localparam int RA = 6;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        irq_enabled;
        logic        halted;
        logic [15:0] hl;
        logic [15:0] de;
        logic [15:0] bc;
        logic [7:0]  flags;
        logic [7:0]  a;
        logic [15:0] sp;
        logic [15:0] pc;
        logic [7:0]  read_data;
    } snapshot_t;

    logic [7:0]  mem [c80_pkg::MEM_DEPTH];
    logic [7:0]  regs [7];
    logic [15:0] pc, sp;
    logic        fs, fz, fac, fp, fcy;
    logic [7:0]  in_buf, out_buf;
    logic        halted, ie, console_mode;
    logic        emit_v;
    logic [7:0]  emit_b;

    snapshot_t expected_snapshots[$];

    function automatic logic [15:0] hl_ptr();
        return {regs[4], regs[5]};
    endfunction

    function automatic logic [7:0] get_r(input logic [2:0] c);
        if (c == 3'd6) return mem[hl_ptr()];
        return regs[c == 3'd7 ? RA : c];
    endfunction

    function automatic void set_r(input logic [2:0] c, input logic [7:0] v);
        if (c == 3'd6) mem[hl_ptr()] = v;
        else regs[c == 3'd7 ? RA : c] = v;
    endfunction

    function automatic logic [15:0] get_rp(input logic [1:0] p);
        if (p == 2'd3) return sp;
        return {regs[2*p], regs[2*p+1]};
    endfunction

    function automatic void set_rp(input logic [1:0] p, input logic [15:0] v);
        if (p == 2'd3) sp = v;
        else begin
            regs[2*p]   = v[15:8];
            regs[2*p+1] = v[7:0];
        end
    endfunction

    function automatic logic [7:0] fetch();
        logic [7:0] v;
        v = mem[pc];
        pc = pc + 16'd1;
        return v;
    endfunction

    function automatic logic [15:0] fetch16();
        logic [7:0] lo;
        lo = fetch();
        return {fetch(), lo};
    endfunction

    function automatic void push16(input logic [15:0] v);
        sp = sp - 16'd1;
        mem[sp] = v[15:8];
        sp = sp - 16'd1;
        mem[sp] = v[7:0];
    endfunction

    function automatic logic [15:0] pop16();
        logic [7:0] lo;
        lo = mem[sp];
        sp = sp + 16'd1;
        pop16 = {mem[sp], lo};
        sp = sp + 16'd1;
    endfunction

    function automatic void set_szp(input logic [7:0] v);
        fs = v[7];
        fz = (v == 8'd0);
        fp = ~^v;
    endfunction

    function automatic logic [7:0] psw();
        return {fs, fz, 1'b0, fac, 1'b0, fp, 1'b1, fcy};
    endfunction

    function automatic void alu(input logic [2:0] op, input logic [7:0] b);
        int unsigned av, bv, c, r;
        av = regs[RA];
        bv = b;
        c  = fcy;
        r  = 0;
        case (op)
            3'd0, 3'd1: begin
                if (op == 3'd0) c = 0;
                r   = av + bv + c;
                fac = ((av & 15) + (bv & 15) + c) > 15;
                fcy = r > 255;
            end
            3'd2, 3'd3: begin
                if (op == 3'd2) c = 0;
                r   = (av - bv - c) & 255;
                fac = (av & 15) < (bv & 15) + c;
                fcy = av < bv + c;
            end
            3'd4: begin r = av & bv; fcy = 1'b0; end
            3'd5: begin r = av ^ bv; fcy = 1'b0; end
            3'd6: begin r = av | bv; fcy = 1'b0; end
            default: begin
                // compare: flags only, Z from equality
                r   = (av - bv) & 255;
                fac = ((av & 15) + ((256 - bv) & 15)) > 15;
                fcy = bv > av;
                set_szp(r[7:0]);
                fz  = (av == bv);
                return;
            end
        endcase
        regs[RA] = r[7:0];
        set_szp(r[7:0]);
    endfunction

    function automatic logic cond_met(input logic [2:0] c);
        case (c)
            3'd0: return !fz;
            3'd1: return fz;
            3'd2: return !fcy;
            3'd3: return fcy;
            3'd4: return !fp;
            3'd5: return fp;
            3'd6: return !fs;
            default: return fs;
        endcase
    endfunction

    function automatic void rotate_misc(input logic [2:0] k);
        logic [7:0] a, corr;
        logic       c, nc;
        a = regs[RA];
        case (k)
            3'd0: begin c = a[7]; a = {a[6:0], c}; fcy = c; end
            3'd1: begin c = a[0]; a = {c, a[7:1]}; fcy = c; end
            3'd2: begin c = a[7]; a = {a[6:0], fcy}; fcy = c; end
            3'd3: begin c = a[0]; a = {fcy, a[7:1]}; fcy = c; end
            3'd4: begin
                corr = 8'h00;
                nc   = fcy;
                if (a[3:0] > 4'd9 || fac) corr[3:0] = 4'h6;
                if (a > 8'h99 || fcy) begin corr[7:4] = 4'h6; nc = 1'b1; end
                fac = ({1'b0, a[3:0]} + {1'b0, corr[3:0]}) > 5'd15;
                a   = a + corr;
                fcy = nc;
                set_szp(a);
            end
            3'd5: a = ~a;
            3'd6: fcy = 1'b1;
            default: fcy = !fcy;
        endcase
        regs[RA] = a;
    endfunction

    function automatic void port_out(input logic [7:0] port);
        if (port == 8'd0) in_buf = regs[RA];
        else if (port == 8'd1) begin
            if (console_mode) begin emit_v = 1'b1; emit_b = regs[RA]; end
            else out_buf = regs[RA];
        end
    endfunction

    function automatic void low_quarter(input logic [7:0] op);
        logic [2:0]  y;
        logic [1:0]  p;
        logic [15:0] t;
        logic [16:0] s;
        logic [7:0]  v;
        y = op[5:3];
        p = op[5:4];
        case (op[2:0])
            3'd0: ;
            3'd1: begin
                if (op[3]) begin
                    s   = {1'b0, hl_ptr()} + {1'b0, get_rp(p)};
                    fcy = s[16];
                    set_rp(2'd2, s[15:0]);
                end else set_rp(p, fetch16());
            end
            3'd2: begin
                case (y)
                    3'd0: mem[get_rp(2'd0)] = regs[RA];
                    3'd1: regs[RA] = mem[get_rp(2'd0)];
                    3'd2: mem[get_rp(2'd1)] = regs[RA];
                    3'd3: regs[RA] = mem[get_rp(2'd1)];
                    3'd4: begin
                        t = fetch16();
                        mem[t] = regs[5];
                        mem[t + 16'd1] = regs[4];
                    end
                    3'd5: begin
                        t = fetch16();
                        regs[5] = mem[t];
                        regs[4] = mem[t + 16'd1];
                    end
                    3'd6: begin t = fetch16(); mem[t] = regs[RA]; end
                    default: begin t = fetch16(); regs[RA] = mem[t]; end
                endcase
            end
            3'd3: set_rp(p, get_rp(p) + (op[3] ? 16'hffff : 16'd1));
            3'd4: begin
                v   = get_r(y);
                fac = (v[3:0] == 4'hf);
                v   = v + 8'd1;
                set_szp(v);
                set_r(y, v);
            end
            3'd5: begin
                v   = get_r(y);
                fac = (v[3:0] == 4'h0);
                v   = v - 8'd1;
                set_szp(v);
                set_r(y, v);
            end
            3'd6: begin v = fetch(); set_r(y, v); end
            default: rotate_misc(y);
        endcase
    endfunction

    function automatic void high_quarter(input logic [7:0] op);
        logic [2:0]  y;
        logic [1:0]  p;
        logic [15:0] t;
        logic [7:0]  port;
        y = op[5:3];
        p = op[5:4];
        case (op[2:0])
            3'd0: if (cond_met(y)) pc = pop16();
            3'd1: begin
                if (op[3]) begin
                    if (p == 2'd0) pc = pop16();
                    else if (p == 2'd2) pc = hl_ptr();
                    else if (p == 2'd3) sp = hl_ptr();
                end else if (p == 2'd3) begin
                    t   = pop16();
                    fs  = t[7];
                    fz  = t[6];
                    fac = t[4];
                    fp  = t[2];
                    fcy = t[0];
                    regs[RA] = t[15:8];
                end else set_rp(p, pop16());
            end
            3'd2: begin
                t = fetch16();
                if (cond_met(y)) pc = t;
            end
            3'd3: begin
                case (y)
                    3'd0: pc = fetch16();
                    3'd1, 3'd3: begin
                        port = fetch();
                        if (port == 8'd0) regs[RA] = in_buf;
                        else if (port == 8'd1) regs[RA] = out_buf;
                    end
                    3'd2: port_out(fetch());
                    3'd4: begin t = hl_ptr(); set_rp(2'd2, pop16()); push16(t); end
                    3'd5: begin t = hl_ptr(); set_rp(2'd2, get_rp(2'd1)); set_rp(2'd1, t); end
                    3'd6: ie = 1'b0;
                    default: ie = 1'b1;
                endcase
            end
            3'd4: begin
                t = fetch16();
                if (cond_met(y)) begin push16(pc); pc = t; end
            end
            3'd5: begin
                if (op[3]) begin
                    t = fetch16();
                    push16(pc);
                    pc = t;
                end else if (p == 2'd3) push16({regs[RA], psw()});
                else push16(get_rp(p));
            end
            3'd6: alu(y, fetch());
            default: begin
                push16(pc);
                pc = {10'd0, op[5:3], 3'd0};
            end
        endcase
    endfunction

    function automatic void run_instruction();
        logic [7:0] op;
        op = fetch();
        if (op == c80_pkg::OP_HLT) halted = 1'b1;
        else if (op[7:6] == 2'b01) set_r(op[5:3], get_r(op[2:0]));
        else if (op[7:6] == 2'b10) alu(op[5:3], get_r(op[2:0]));
        else if (op[7:6] == 2'b00) low_quarter(op);
        else high_quarter(op);
    endfunction

    function automatic snapshot_t apply_item(input logic [c80_pkg::IN_W-1:0] item);
        c80_pkg::kind_t kind;
        logic [15:0]    addr;
        logic [7:0]     data;
        snapshot_t      sn;
        kind   = c80_pkg::kind_t'(item[1:0]);
        addr   = item[17:2];
        data   = item[25:18];
        emit_v = 1'b0;
        emit_b = 8'd0;
        sn     = '0;
        case (kind)
            c80_pkg::KIND_WRITE: mem[addr] = data;
            c80_pkg::KIND_READ:  sn.read_data = mem[addr];
            c80_pkg::KIND_EXEC:  if (!halted) run_instruction();
            default:             in_buf = data;
        endcase
        sn.pc          = pc;
        sn.sp          = sp;
        sn.a           = regs[RA];
        sn.flags       = psw();
        sn.bc          = get_rp(2'd0);
        sn.de          = get_rp(2'd1);
        sn.hl          = get_rp(2'd2);
        sn.halted      = halted;
        sn.irq_enabled = ie;
        sn.out_valid   = emit_v;
        sn.out_byte    = emit_v ? emit_b : out_buf;
        return sn;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    snapshot_t got, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (mem[i]) mem[i] = 8'd0;
            foreach (regs[i]) regs[i] = 8'd0;
            pc = 16'd0;
            sp = c80_pkg::SP_RESET;
            {fs, fz, fac, fp, fcy} = 5'd0;
            in_buf = 8'd0;
            out_buf = 8'd0;
            halted = 1'b0;
            ie = 1'b0;
            console_mode = 1'b0;
            expected_snapshots.delete();
            errors = 0;
        end else begin
            // result side first: the front entry is always from an older transfer
            if (m_tvalid && m_tready) begin
                got = snapshot_t'(m_tdata[$bits(snapshot_t)-1:0]);
                if (expected_snapshots.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, got);
                    errors++;
                end else begin
                    want = expected_snapshots.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("pc", want.pc, got.pc);
                    check_field("sp", want.sp, got.sp);
                    check_field("reg_a", want.a, got.a);
                    check_field("flag_byte", want.flags, got.flags);
                    check_field("pair_bc", want.bc, got.bc);
                    check_field("pair_de", want.de, got.de);
                    check_field("pair_hl", want.hl, got.hl);
                    check_field("halted", want.halted, got.halted);
                    check_field("irq_enabled", want.irq_enabled, got.irq_enabled);
                    check_field("out_valid", want.out_valid, got.out_valid);
                    check_field("out_byte", want.out_byte, got.out_byte);
                end
            end
            if (cfg_wr_en) console_mode = cfg_wr_data;
            if (s_tvalid && s_tready) expected_snapshots.push_back(apply_item(s_tdata));
        end
        pending = expected_snapshots.size();
        next_pc = pc;
    end

endmodule

[tb/sv/cpu_8080_instruction_core_tb.sv]
`timescale 1ns / 1ps
// Top of the core testbench: clock, reset, stimulus, backpressure and verdict.
module cpu_8080_instruction_core_tb;

    localparam int ITEM_TARGET = 750;
    localparam int STALL_LIMIT = 200000;  // covers the memory clearing pass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [c80_pkg::IN_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [c80_pkg::OUT_W-1:0] m_tdata;
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_wr_data = 1'b0;
    int                        errors, pending;
    logic [15:0]               next_pc;

    int items_sent = 0;
    int burst_left = 0;
    int idle_count = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    cpu_8080_instruction_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    cpu_8080_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .errors      (errors),
        .pending     (pending),
        .next_pc     (next_pc)
    );

    // receiver backpressure: steps through four m_tready modes in turn
    int rx_cycle = 0;
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 300) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_cycle % 7 < 4);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input c80_pkg::kind_t kind, input logic [15:0] addr,
                             input logic [7:0] data);
        logic ok;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, data, addr, kind};
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    task automatic set_console_mode(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_bytes(input logic [15:0] base, input logic [7:0] code[$]);
        foreach (code[i]) send_item(c80_pkg::KIND_WRITE, base + 16'(i), code[i]);
    endtask

    function automatic logic [7:0] program_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == c80_pkg::OP_HLT) ? 8'h00 : b;
    endfunction

    task automatic noise_item();
        case ($urandom_range(0, 2))
            0: send_item(c80_pkg::KIND_READ, 16'($urandom), 8'($urandom));
            1: send_item(c80_pkg::KIND_WRITE, 16'($urandom), 8'($urandom));
            default: send_item(c80_pkg::KIND_INBUF, 16'($urandom), 8'($urandom));
        endcase
    endtask

    logic [7:0] code[$];
    logic [15:0] base;
    int blk;

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes
        send_item(c80_pkg::KIND_WRITE, 16'hffff, 8'hff);
        send_item(c80_pkg::KIND_READ, 16'hffff, 8'h00);
        send_item(c80_pkg::KIND_READ, 16'h0000, 8'hff);
        send_item(c80_pkg::KIND_INBUF, 16'h0000, 8'hff);

        // directed program: add with carry into DAA, port traffic, call alias,
        // restart, return, DAD SP, DCX
        code = '{8'h3e, 8'hff, 8'hc6, 8'h01, 8'h27, 8'hd3, 8'h01, 8'hdb, 8'h01,
                 8'hd3, 8'h00, 8'hcb, 8'h00, 8'hd3, 8'h05, 8'h31, 8'hff, 8'hff,
                 8'hdd, 8'h20, 8'h00};
        load_bytes(16'h0000, code);
        code = '{8'hff, 8'h39, 8'h0b};
        load_bytes(16'h0020, code);
        send_item(c80_pkg::KIND_WRITE, 16'h0038, 8'hc9);
        repeat (14) send_item(c80_pkg::KIND_EXEC, 16'h0000, 8'h00);

        // console output
        wait_drained();
        set_console_mode(1'b1);
        code = '{8'hd3, 8'h01};
        load_bytes(next_pc, code);
        send_item(c80_pkg::KIND_EXEC, 16'h0000, 8'h00);

        // random programs placed at the current PC
        blk = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_drained();
            if (blk % 8 == 0) set_console_mode(blk[3]);
            base = next_pc;
            code.delete();
            repeat (8) code.push_back(program_byte());
            load_bytes(base, code);
            repeat ($urandom_range(4, 7)) begin
                if ($urandom_range(0, 4) == 0) noise_item();
                send_item(c80_pkg::KIND_EXEC, 16'($urandom), 8'($urandom));
            end
            blk++;
        end

        // halt, then executes that must do nothing
        wait_drained();
        send_item(c80_pkg::KIND_WRITE, next_pc, c80_pkg::OP_HLT);
        repeat (3) send_item(c80_pkg::KIND_EXEC, 16'h0000, 8'h00);
        send_item(c80_pkg::KIND_WRITE, 16'h1234, 8'h5a);
        send_item(c80_pkg::KIND_READ, 16'h1234, 8'h00);
        send_item(c80_pkg::KIND_INBUF, 16'h0000, 8'ha5);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
